// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== src/tia_pkg.sv =====
`default_nettype none
package tia_pkg;

	// Fixed field widths of the stream payload.
	localparam int VAL_W  = 64;
	localparam int ERR_W  = 2;
	localparam int KIND_W = 3;

	localparam int S_TDATA_W = 136;
	localparam int S_TUSER_W = 5;
	localparam int M_TDATA_W = 72;
	localparam int M_TUSER_W = 1;

	// Operator codes.
	localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
	localparam logic [KIND_W-1:0] KIND_MOD = 3'd4;
	localparam logic [KIND_W-1:0] KIND_POW = 3'd5;

	// Error codes.
	localparam logic [ERR_W-1:0] ERR_DIV_ZERO = 2'd0;
	localparam logic [ERR_W-1:0] ERR_BAD_OP   = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_MUL,
		ST_DIV,
		ST_POW,
		ST_POW_WAIT,
		ST_FINISH
	} state_t;

	// How the captured operation is completed.
	typedef enum logic [1:0] {
		CLS_IMM,
		CLS_MUL,
		CLS_DIV,
		CLS_POW
	} cls_t;

	typedef struct packed {
		logic load;
		logic mul_start;
		logic div_start;
		logic pow_init;
		logic pow_start;
		logic pow_update;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		cls_t cls;
		logic mul_done;
		logic div_done;
		logic exp_zero;
		logic out_free;
	} ctrl_stat_t;

endpackage
`default_nettype wire

// ===== src/tia_mul.sv =====
`default_nettype none
// Sequential multiplier: low DATA_WIDTH bits of x*y, one chunk of y per cycle.
module tia_mul #(
	parameter int DATA_WIDTH = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DATA_WIDTH-1:0] x,
	input  wire logic [DATA_WIDTH-1:0] y,
	output logic [DATA_WIDTH-1:0]      product,
	output logic                       done
);
	localparam int W   = DATA_WIDTH;
	localparam int CH  = (W < 16) ? W : 16;
	localparam int NCH = (W + CH - 1) / CH;
	localparam int CW  = $clog2(NCH + 1);

	logic [W-1:0]    x_q, y_q, acc_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q, done_q;
	logic [W+CH-1:0] pp;

	assign pp = {{CH{1'b0}}, x_q} * {{W{1'b0}}, y_q[CH-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NCH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			y_q   <= y;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp[W-1:0];
			x_q   <= x_q << CH;
			y_q   <= y_q >> CH;
		end
	end

	assign product = acc_q;
	assign done    = done_q;

endmodule
`default_nettype wire

// ===== src/tia_div.sv =====
`default_nettype none
// Restoring divider on unsigned magnitudes, one quotient bit per cycle.
module tia_div #(
	parameter int DATA_WIDTH = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DATA_WIDTH-1:0] num,
	input  wire logic [DATA_WIDTH-1:0] den,
	output logic [DATA_WIDTH-1:0]      quo,
	output logic [DATA_WIDTH-1:0]      rem,
	output logic                       done
);
	localparam int W  = DATA_WIDTH;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  rem_q, quo_q, den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [W:0]    shifted, diff;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
			end else begin
				rem_q <= shifted[W-1:0];
			end
			quo_q <= {quo_q[W-2:0], ~diff[W]};
		end
	end

	assign quo  = quo_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule
`default_nettype wire

// ===== src/tia_datapath.sv =====
`default_nettype none
// Operand registers, arithmetic units, result selection and output register.
module tia_datapath import tia_pkg::*; #(
	parameter int DATA_WIDTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctrl_cmd_t         cmd,
	output ctrl_stat_t             stat,
	input  wire logic              left_is_error,
	input  wire logic [VAL_W-1:0]  left_value,
	input  wire logic [ERR_W-1:0]  left_error,
	input  wire logic [KIND_W-1:0] kind,
	input  wire logic              right_is_error,
	input  wire logic [VAL_W-1:0]  right_value,
	input  wire logic [ERR_W-1:0]  right_error,
	input  wire logic              m_tready,
	output logic                   m_tvalid,
	output logic                   result_is_error,
	output logic [VAL_W-1:0]       result_value,
	output logic [ERR_W-1:0]       result_error
);
	localparam int W = DATA_WIDTH;

	logic              lerr_q, rerr_q;
	logic [ERR_W-1:0]  lcode_q, rcode_q;
	logic [KIND_W-1:0] kind_q;
	logic [W-1:0]      a_q, b_q;
	logic [W-1:0]      r_q, base_q, e_q;

	logic              m_valid_q;
	logic              res_err_q;
	logic [VAL_W-1:0]  res_val_q;
	logic [ERR_W-1:0]  res_code_q;

	logic              a_neg, b_neg;
	logic [W-1:0]      a_mag, b_mag;
	logic [W-1:0]      m0_x, m0_y, prod0, prod1;
	logic              done0, done1;
	logic [W-1:0]      quo, rem, q_signed, r_signed, pow_special;
	logic              div_done;

	logic              fin_err;
	logic [ERR_W-1:0]  fin_code;
	logic [W-1:0]      fin_val;
	cls_t              cls;

	assign a_neg = a_q[W-1];
	assign b_neg = b_q[W-1];
	assign a_mag = a_neg ? -a_q : a_q;
	assign b_mag = b_neg ? -b_q : b_q;

	// Lane 0 serves a plain multiply or the running product; lane 1 squares the base.
	assign m0_x = cmd.mul_start ? a_q : r_q;
	assign m0_y = cmd.mul_start ? b_q : base_q;

	tia_mul #(.DATA_WIDTH(W)) u_mul0 (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start | cmd.pow_start),
		.x       (m0_x),
		.y       (m0_y),
		.product (prod0),
		.done    (done0)
	);

	tia_mul #(.DATA_WIDTH(W)) u_mul1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.pow_start),
		.x       (base_q),
		.y       (base_q),
		.product (prod1),
		.done    (done1)
	);

	tia_div #(.DATA_WIDTH(W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (a_mag),
		.den    (b_mag),
		.quo    (quo),
		.rem    (rem),
		.done   (div_done)
	);

	assign q_signed = (a_neg ^ b_neg) ? -quo : quo;
	assign r_signed = a_neg ? -rem : rem;

	// Negative exponent: only bases of one and minus one survive.
	always_comb begin
		if (a_q == W'(1)) begin
			pow_special = W'(1);
		end else if (a_q == '1) begin
			pow_special = b_q[0] ? '1 : W'(1);
		end else begin
			pow_special = '0;
		end
	end

	always_comb begin
		fin_err  = 1'b0;
		fin_code = '0;
		fin_val  = '0;
		cls      = CLS_IMM;
		if (lerr_q) begin
			fin_err  = 1'b1;
			fin_code = lcode_q;
		end else if (rerr_q) begin
			fin_err  = 1'b1;
			fin_code = rcode_q;
		end else begin
			case (kind_q)
				KIND_ADD: fin_val = a_q + b_q;
				KIND_SUB: fin_val = a_q - b_q;
				KIND_MUL: begin
					fin_val = prod0;
					cls     = CLS_MUL;
				end
				KIND_DIV, KIND_MOD: begin
					if (b_q == '0) begin
						fin_err  = 1'b1;
						fin_code = ERR_DIV_ZERO;
					end else begin
						fin_val = (kind_q == KIND_DIV) ? q_signed : r_signed;
						cls     = CLS_DIV;
					end
				end
				KIND_POW: begin
					if (b_neg) begin
						fin_val = pow_special;
					end else begin
						fin_val = r_q;
						cls     = CLS_POW;
					end
				end
				default: begin
					fin_err  = 1'b1;
					fin_code = ERR_BAD_OP;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lerr_q  <= left_is_error;
			rerr_q  <= right_is_error;
			lcode_q <= left_error;
			rcode_q <= right_error;
			kind_q  <= kind;
			a_q     <= left_value[W-1:0];
			b_q     <= right_value[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pow_init) begin
			r_q    <= W'(1);
			base_q <= a_q;
			e_q    <= b_q;
		end else if (cmd.pow_update) begin
			if (e_q[0]) begin
				r_q <= prod0;
			end
			base_q <= prod1;
			e_q    <= e_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_err_q  <= fin_err;
			res_val_q  <= VAL_W'(signed'(fin_val));
			res_code_q <= fin_code;
		end
	end

	// Both lanes finish together during a power step; a plain multiply runs lane 0 only.
	assign stat.cls      = cls;
	assign stat.mul_done = done0 | done1;
	assign stat.div_done = div_done;
	assign stat.exp_zero = (e_q == '0);
	assign stat.out_free = !m_valid_q || m_tready;

	assign m_tvalid        = m_valid_q;
	assign result_is_error = res_err_q;
	assign result_value    = res_val_q;
	assign result_error    = res_code_q;

endmodule
`default_nettype wire

// ===== src/tia_ctrl.sv =====
`default_nettype none
// Sequencer: takes one item, drives the arithmetic units, hands off the result.
module tia_ctrl import tia_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire ctrl_stat_t stat,
	output ctrl_cmd_t       cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (stat.cls)
					CLS_MUL: state_d = ST_MUL;
					CLS_DIV: state_d = ST_DIV;
					CLS_POW: state_d = ST_POW;
					default: state_d = ST_FINISH;
				endcase
			end
			ST_MUL: begin
				if (stat.mul_done) state_d = ST_FINISH;
			end
			ST_DIV: begin
				if (stat.div_done) state_d = ST_FINISH;
			end
			ST_POW: begin
				state_d = stat.exp_zero ? ST_FINISH : ST_POW_WAIT;
			end
			ST_POW_WAIT: begin
				if (stat.mul_done) state_d = ST_POW;
			end
			ST_FINISH: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_DISPATCH: begin
				cmd.mul_start = (stat.cls == CLS_MUL);
				cmd.div_start = (stat.cls == CLS_DIV);
				cmd.pow_init  = (stat.cls == CLS_POW);
			end
			ST_POW: begin
				cmd.pow_start = !stat.exp_zero;
			end
			ST_POW_WAIT: begin
				cmd.pow_update = stat.mul_done;
			end
			ST_FINISH: begin
				cmd.finish = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== src/tagged_integer_alu.sv =====
// Sequence per item: the input transfer loads the operands; dispatch then sends errors, add,
// subtract and the immediate cases straight to finish, and starts the multiplier for multiply
// and the divider for divide/modulo. Power runs one multiplier step per exponent bit up to the
// highest set bit. One item is in flight at a time: the next input is taken only after the
// result is loaded into the output register, and a result left waiting holds off the next one.
// Reset (arst_n low, asynchronous) empties the output register and returns the sequencer to idle.
`default_nettype none
module tagged_integer_alu import tia_pkg::*; #(
	parameter int DATA_WIDTH = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Input stream.
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// s_tdata, from bit 0: left_value[63:0], left_error[65:64], right_value[129:66],
	// right_error[131:130], zero fill [135:132].
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	// s_tuser, from bit 0: left_is_error[0], kind[3:1], right_is_error[4].
	input  wire logic [S_TUSER_W-1:0] s_tuser,
	// Result stream.
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// m_tdata, from bit 0: result_value[63:0], result_error[65:64], zero fill [71:66].
	output logic [M_TDATA_W-1:0]      m_tdata,
	// m_tuser, from bit 0: result_is_error[0].
	output logic [M_TUSER_W-1:0]      m_tuser
);
	// The controller and the datapath talk only through these two bundles.
	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	logic             result_is_error;
	logic [VAL_W-1:0] result_value;
	logic [ERR_W-1:0] result_error;

	tia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Operands are captured on the input transfer; arithmetic works on the low
	// DATA_WIDTH bits and the result is sign-extended back to 64 bits.
	tia_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.left_is_error   (s_tuser[0]),
		.left_value      (s_tdata[63:0]),
		.left_error      (s_tdata[65:64]),
		.kind            (s_tuser[3:1]),
		.right_is_error  (s_tuser[4]),
		.right_value     (s_tdata[129:66]),
		.right_error     (s_tdata[131:130]),
		.m_tready        (m_tready),
		.m_tvalid        (m_tvalid),
		.result_is_error (result_is_error),
		.result_value    (result_value),
		.result_error    (result_error)
	);

	// Pack the result transfer; the fill bits above the error code are zero.
	assign m_tdata = {(M_TDATA_W - VAL_W - ERR_W)'(0), result_error, result_value};
	assign m_tuser = result_is_error;

endmodule
`default_nettype wire

// ===== src/tia_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
// Port-level checks for the tagged ALU.
module tia_checker import tia_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic [M_TUSER_W-1:0] m_tuser
);
	// A waiting result keeps its contents until it is taken.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// Only one item is worked on at a time.
	`ASSERT_NEXT(a_one_in_flight, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// An error result carries no number.
	`ASSERT_SAME(a_err_no_value, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[VAL_W-1:0] == '0)

	// A number result carries error code zero.
	`ASSERT_SAME(a_val_no_code, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata[VAL_W+ERR_W-1:VAL_W] == '0)

endmodule

bind tagged_integer_alu tia_checker u_tia_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
